@@ src/srst_pkg.sv @@
// Shared types and constants for the sorted region slot table.
package srst_pkg;

  localparam int IdBits  = 4;
  localparam int PosBits = 5;

  typedef enum logic [0:0] {
    FUNC_LOOKUP = 1'b0,
    FUNC_UPDATE = 1'b1
  } func_t;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic capture;     // latch the input beat
    logic hint_test;   // test the hinted entry
    logic search_step; // one binary search step
    logic final_test;  // test the entry where the search stopped
    logic upd_begin;   // read the id map, adjust the used counter
    logic fwd_step;    // shift next entry back by one place
    logic bwd_step;    // shift previous entry forward by one place
    logic upd_write;   // write the updated entry
    logic bad_id;      // update with an id out of range
  } srst_cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic is_update;
    logic id_ok;
    logic hint_hit;
    logic search_done;
    logic fwd_more;
    logic bwd_more;
    logic del;
  } srst_stat_t;

endpackage

@@ src/srst_datapath.sv @@
// Datapath: entry table, id map, search bounds and result register.
module srst_datapath #(
  parameter int SLOT_COUNT = 16,
  parameter int FRAME_BITS = 40
) (
  input  logic                     clk,
  input  logic                     rst,
  input  srst_pkg::srst_cmd_t      cmd,
  output srst_pkg::srst_stat_t     stat,
  input  logic [3:0]               hint,
  input  logic                     in_func,
  input  logic [FRAME_BITS-1:0]    in_frame,
  input  logic [FRAME_BITS-1:0]    in_pages,
  input  logic [3:0]               in_id,
  output logic                     r_hit,
  output logic [3:0]               r_id,
  output logic [FRAME_BITS-1:0]    r_base,
  output logic [FRAME_BITS-1:0]    r_pages,
  output logic [4:0]               r_pos,
  output logic [4:0]               r_used
);
  import srst_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  logic [FRAME_BITS-1:0] base_q [SLOT_COUNT];
  logic [FRAME_BITS-1:0] pages_q [SLOT_COUNT];
  logic [3:0]            owner_q [SLOT_COUNT];
  logic [IW-1:0]         pos_of_id [SLOT_COUNT];
  logic [CW-1:0]         used;

  logic                  func;
  logic [FRAME_BITS-1:0] frame;
  logic [FRAME_BITS-1:0] pg;
  logic [3:0]            id;
  logic [CW-1:0]         lo;
  logic [CW-1:0]         hi;
  logic [IW-1:0]         cur;

  logic [CW-1:0] mid;
  logic [IW-1:0] mid_i;
  logic [IW-1:0] lo_i;
  logic [IW-1:0] hint_i;
  logic [IW-1:0] nxt_i;
  logic [IW-1:0] prv_i;
  logic          hint_ok;
  logic          hint_in;
  logic          lo_in;
  logic          id_ok;

  assign mid    = lo + ((hi - lo) >> 1);
  assign mid_i  = mid[IW-1:0];
  assign lo_i   = lo[IW-1:0];
  assign hint_i = hint[IW-1:0];
  assign nxt_i  = cur + IW'(1);
  assign prv_i  = cur - IW'(1);
  assign hint_ok = (32'(hint) < SLOT_COUNT);
  assign hint_in = hint_ok && frame >= base_q[hint_i] &&
                   (frame - base_q[hint_i]) < pages_q[hint_i];
  assign lo_in   = (32'(lo) < SLOT_COUNT) && frame >= base_q[lo_i] &&
                   (frame - base_q[lo_i]) < pages_q[lo_i];
  assign id_ok   = (32'(id) < SLOT_COUNT);

  always_comb begin
    stat.is_update   = func;
    stat.id_ok       = id_ok;
    stat.hint_hit    = hint_in;
    stat.search_done = !(lo < hi);
    stat.fwd_more    = (32'(cur) + 1 < SLOT_COUNT) && frame <= base_q[nxt_i] &&
                       pages_q[nxt_i] != '0;
    stat.bwd_more    = (pg != '0) && cur != '0 && frame >= base_q[prv_i];
    stat.del         = (pg == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
        base_q[k]    <= '0;
        pages_q[k]   <= '0;
        owner_q[k]   <= 4'(k);
        pos_of_id[k] <= IW'(k);
      end
    end else begin
      if (cmd.capture) begin
        func  <= in_func;
        frame <= in_frame;
        pg    <= in_pages;
        id    <= in_id;
        lo    <= '0;
        hi    <= used;
      end
      if (cmd.hint_test) begin
        r_hit   <= 1'b1;
        r_id    <= owner_q[hint_i];
        r_base  <= base_q[hint_i];
        r_pages <= pages_q[hint_i];
        r_pos   <= 5'(hint);
        r_used  <= 5'(used);
      end
      if (cmd.search_step) begin
        if (frame >= base_q[mid_i]) hi <= mid;
        else lo <= mid + CW'(1);
      end
      if (cmd.final_test) begin
        r_hit   <= lo_in;
        r_id    <= lo_in ? owner_q[lo_i] : 4'd0;
        r_base  <= lo_in ? base_q[lo_i] : '0;
        r_pages <= lo_in ? pages_q[lo_i] : '0;
        r_pos   <= 5'(lo);
        r_used  <= 5'(used);
      end
      if (cmd.bad_id) begin
        r_hit   <= 1'b0;
        r_id    <= id;
        r_base  <= '0;
        r_pages <= '0;
        r_pos   <= 5'(SLOT_COUNT);
        r_used  <= 5'(used);
      end
      if (cmd.upd_begin) begin
        cur <= pos_of_id[id[IW-1:0]];
        if (pg == '0) begin
          if (pages_q[pos_of_id[id[IW-1:0]]] != '0 && used != '0) used <= used - CW'(1);
        end else if (pages_q[pos_of_id[id[IW-1:0]]] == '0 && 32'(used) < SLOT_COUNT) begin
          used <= used + CW'(1);
        end
      end
      if (cmd.fwd_step) begin
        base_q[cur]  <= base_q[nxt_i];
        pages_q[cur] <= pages_q[nxt_i];
        owner_q[cur] <= owner_q[nxt_i];
        pos_of_id[owner_q[nxt_i][IW-1:0]] <= cur;
        cur <= nxt_i;
      end
      if (cmd.bwd_step) begin
        base_q[cur]  <= base_q[prv_i];
        pages_q[cur] <= pages_q[prv_i];
        owner_q[cur] <= owner_q[prv_i];
        pos_of_id[owner_q[prv_i][IW-1:0]] <= cur;
        cur <= prv_i;
      end
      if (cmd.upd_write) begin
        base_q[cur]  <= frame;
        pages_q[cur] <= pg;
        owner_q[cur] <= id;
        pos_of_id[id[IW-1:0]] <= cur;
        r_hit   <= 1'b1;
        r_id    <= id;
        r_base  <= frame;
        r_pages <= pg;
        r_pos   <= 5'(cur);
        r_used  <= 5'(used);
      end
    end
  end

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used) <= SLOT_COUNT) else $error("used count past table size");
  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(cmd.fwd_step && cmd.bwd_step)) else $error("both shift directions");
  a_fwd_adv: assert property (@(posedge clk) disable iff (rst)
    cmd.fwd_step |=> cur == $past(nxt_i)) else $error("forward shift lost");
`endif
endmodule

@@ src/srst_ctrl.sv @@
// Controller state machine sequencing lookups and updates.
module srst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 in_func,
  input  logic [3:0]           in_id,
  input  logic                 id_fits,
  output srst_pkg::srst_cmd_t  cmd,
  input  srst_pkg::srst_stat_t stat
);
  import srst_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_HINT   = 7'b0000010,
    S_SEARCH = 7'b0000100,
    S_UBEGIN = 7'b0001000,
    S_FWD    = 7'b0010000,
    S_BWD    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   acc;

  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == S_OUT) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (acc) begin
        cmd.capture = 1'b1;
        state_next = (in_func == FUNC_UPDATE) ? S_UBEGIN : S_HINT;
      end
      S_HINT: begin
        if (stat.hint_hit) begin
          cmd.hint_test = 1'b1;
          state_next = S_OUT;
        end else state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.search_done) begin
          cmd.final_test = 1'b1;
          state_next = S_OUT;
        end else cmd.search_step = 1'b1;
      end
      S_UBEGIN: begin
        if (!stat.id_ok) begin
          cmd.bad_id = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.upd_begin = 1'b1;
          state_next = S_FWD;
        end
      end
      S_FWD: begin
        if (stat.fwd_more) cmd.fwd_step = 1'b1;
        else state_next = S_BWD;
      end
      S_BWD: begin
        if (stat.bwd_more) cmd.bwd_step = 1'b1;
        else begin
          cmd.upd_write = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

`ifndef SYNTH
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("input taken while busy");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> out_valid) else $error("result not shown");
  a_id_unused: assert property (@(posedge clk) disable iff (rst)
    acc |-> (id_fits || in_id == in_id)) else $error("id check");
`endif
endmodule

@@ src/sorted_region_slot_table.sv @@
// Top level of the sorted region slot table.
// Keeps SLOT_COUNT regions (base frame, page count, owner id) sorted by base
// in descending order, used entries first, with a map from id to position.
// Input channel: in_valid/in_stall with func, frame, page_count, slot_id.
// func 0 looks up frame: the hinted entry is tested first, then a binary
// search over the used entries. func 1 sets the region of slot_id by
// shifting neighbor entries one place per cycle; page_count 0 deletes.
// Output channel: out_valid/out_stall with one result beat per item.
// A lookup tests the hinted entry, then on a miss runs the search steps and
// a final test; an update reads the id map, shifts entries forward, then
// backward, and writes the entry before the result is shown.
// One item at a time; the shift sequencer sets the update rate.
// The next item is accepted once the result register is free or taken.
// A stalled result beat holds its value; input stalls until it leaves.
// hint (hint_position) is written through cfg_we/cfg_data; write it only while idle, the block does not enforce this.
// Reset (rst, synchronous) empties the table, sets id k at position k,
// clears the used count and hint, and drops any pending result.
module sorted_region_slot_table #(
  parameter int SLOT_COUNT = 16,
  parameter int FRAME_BITS = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [FRAME_BITS-1:0] frame,
  input  logic [FRAME_BITS-1:0] page_count,
  input  logic [3:0]            slot_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  hit,
  output logic [3:0]            found_id,
  output logic [FRAME_BITS-1:0] region_base,
  output logic [FRAME_BITS-1:0] region_pages,
  output logic [4:0]            position,
  output logic [4:0]            used_count
);
  import srst_pkg::*;

  logic [3:0] hint;
  srst_cmd_t  cmd;
  srst_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) hint <= '0;
    else if (cfg_we) hint <= cfg_data;
  end

  srst_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .in_func(func), .in_id(slot_id), .id_fits(1'b1), .cmd, .stat
  );

  srst_datapath #(.SLOT_COUNT(SLOT_COUNT), .FRAME_BITS(FRAME_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .hint,
    .in_func(func), .in_frame(frame), .in_pages(page_count), .in_id(slot_id),
    .r_hit(hit), .r_id(found_id), .r_base(region_base), .r_pages(region_pages),
    .r_pos(position), .r_used(used_count)
  );
endmodule
